>>> rtl/bitmap_run_search_defines.svh
// Assertion macros for the bitmap run search block.
`ifndef BITMAP_RUN_SEARCH_DEFINES_SVH
`define BITMAP_RUN_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define BRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bitmap_run_search assertion failed");

// Condition that must never be true outside reset.
`define BRS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("bitmap_run_search forbidden condition seen");

`else

`define BRS_ASSERT(lbl, prop)
`define BRS_NEVER(lbl, cond)

`endif

`endif

>>> rtl/brs_pkg.sv
// Shared types and constants of the bitmap run search block.
package brs_pkg;

  // Width of index, length and answer fields.
  localparam int FW = 13;
  // Width of the word index field and the number of words it reaches.
  localparam int WIW = 6;
  localparam int WR_WORDS = 2 ** WIW;
  // Width of the stored word field.
  localparam int WDW = 64;

  // Item kinds.
  typedef enum logic [2:0] {
    KIND_WRITE      = 3'd0,
    KIND_FIND_FIRST = 3'd1,
    KIND_FIND_LAST  = 3'd2,
    KIND_COUNT_UP   = 3'd3,
    KIND_COUNT_DOWN = 3'd4,
    KIND_TEST_FWD   = 3'd5,
    KIND_TEST_BWD   = 3'd6,
    KIND_NONE       = 3'd7
  } kind_e;

endpackage

>>> rtl/brs_ram.sv
// Generic one-write one-read RAM with registered read data.
module brs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, register the read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/bitmap_run_search.sv
// Top level of the bitmap run search block: sequencer, bit walker and word store.
//
//   channel   direction  handshake                  fields
//   item      in         start & !busy              kind, word_index, word_data,
//                                                   first_index, last_index, run_length
//   result    out        result_valid_o (1 cycle)   answer, found
//
// A write or an immediate answer goes straight to the result cycle. A walk first
// splits the start position into word index and bit offset (reciprocal multiply),
// then evaluates one bit at a time, fetching and loading each word inside the map
// through the single RAM read port, and ends with the result cycle.
// Reset clears the word valid bits at once, so the bitmap reads as zero.
// The receiver cannot stall; busy stays high until the result cycle has passed.
`include "bitmap_run_search_defines.svh"

module bitmap_run_search #(
  parameter int MAP_BITS  = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic [2:0]                   kind_i,
  input  logic [brs_pkg::WIW-1:0]      word_index_i,
  input  logic [brs_pkg::WDW-1:0]      word_data_i,
  input  logic [brs_pkg::FW-1:0]       first_index_i,
  input  logic [brs_pkg::FW-1:0]       last_index_i,
  input  logic [brs_pkg::FW-1:0]       run_length_i,
  output logic                         busy,
  output logic                         result_valid_o,
  output logic [brs_pkg::FW-1:0]       answer_o,
  output logic                         found_o
);
  import brs_pkg::*;

  localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int RD  = NUM_WORDS < WR_WORDS ? NUM_WORDS : WR_WORDS;
  localparam int RAW = RD > 1 ? $clog2(RD) : 1;
  localparam int PW  = ($clog2(MAP_BITS + 1) > FW ? $clog2(MAP_BITS + 1) : FW) + 1;
  localparam int OW  = $clog2(WORD_BITS);
  localparam int SH  = PW + OW;
  localparam int MW  = 2 * PW + 1;

  localparam logic [PW-1:0]   MAP_P   = PW'(MAP_BITS);
  localparam logic [PW-1:0]   MAP_M1  = PW'(MAP_BITS - 1);
  localparam logic [OW-1:0]   OFF_TOP = OW'(WORD_BITS - 1);
  localparam logic [PW-1:0]   WB_P    = PW'(WORD_BITS);
  localparam logic [PW:0]     RECIP   =
    (PW+1)'(((64'd1 << SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state_q, state_d;
  kind_e                kind_q, kind_d;
  logic [FW-1:0]        first_q, first_d, last_q, last_d, len_q, len_d;
  logic [PW-1:0]        p_q, p_d, lim_q, lim_d, run_q, run_d, quo_q, quo_d;
  logic [OW-1:0]        off_q, off_d;
  logic [WORD_BITS-1:0] w_q, w_d;
  logic [FW-1:0]        ans_q, ans_d;
  logic                 found_q, found_d;
  logic [RD-1:0]        valid_q, valid_d;

  logic                 ram_we;
  logic [RAW-1:0]       ram_waddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [PW-1:0]        first_x, last_x, len_x, run_n, p_n, start_p;
  logic [MW-1:0]        prod;
  logic [PW-1:0]        quo_n, off_n;
  logic                 bit_v, step_up, wrap, first_le_last;

  // Word store.
  brs_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(RD)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (word_data_i[WORD_BITS-1:0]),
    .raddr_i (quo_q[RAW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ram_waddr      = RAW'(word_index_i);
  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);
  assign answer_o       = ans_q;
  assign found_o        = found_q;

  // Sequencer and shared walk unit.
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    first_d = first_q;
    last_d  = last_q;
    len_d   = len_q;
    p_d     = p_q;
    lim_d   = lim_q;
    run_d   = run_q;
    quo_d   = quo_q;
    off_d   = off_q;
    w_d     = w_q;
    ans_d   = ans_q;
    found_d = found_q;
    valid_d = valid_q;
    ram_we  = 1'b0;

    first_x = PW'(first_index_i);
    last_x  = PW'(last_index_i);
    len_x   = PW'(len_q);
    first_le_last = (first_index_i <= last_index_i);
    start_p = first_x;

    prod  = MW'(p_q) * MW'(RECIP);
    quo_n = PW'(prod >> SH);
    off_n = p_q - quo_n * WB_P;

    bit_v   = (p_q < MAP_P) ? w_q[off_q] : 1'b0;
    run_n   = bit_v ? run_q + PW'(1) : '0;
    step_up = (kind_q == KIND_FIND_FIRST) || (kind_q == KIND_COUNT_UP) ||
              (kind_q == KIND_TEST_FWD);
    p_n     = step_up ? p_q + PW'(1) : p_q - PW'(1);
    wrap    = step_up ? (off_q == OFF_TOP) : (off_q == '0);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d  = kind_e'(kind_i);
          first_d = first_index_i;
          last_d  = last_index_i;
          len_d   = run_length_i;
          run_d   = '0;
          ans_d   = '0;
          found_d = 1'b0;
          state_d = S_DIV;
          unique case (kind_e'(kind_i))
            KIND_WRITE: begin
              if (32'(word_index_i) < RD) begin
                ram_we = 1'b1;
                valid_d[ram_waddr] = 1'b1;
              end
              state_d = S_DONE;
            end
            KIND_FIND_FIRST: begin
              lim_d   = (last_x < MAP_P) ? last_x : MAP_P;
              if (run_length_i == '0) begin
                ans_d   = first_le_last ? first_index_i : last_index_i;
                found_d = first_le_last;
                state_d = S_DONE;
              end
            end
            KIND_FIND_LAST: begin
              lim_d   = first_x;
              start_p = (last_x < MAP_M1) ? last_x : MAP_M1;
              if (run_length_i == '0) begin
                ans_d   = first_le_last ? last_index_i + FW'(1) : first_index_i;
                found_d = first_le_last;
                state_d = S_DONE;
              end else if (last_x < first_x + PW'(run_length_i)) begin
                ans_d   = first_index_i;
                state_d = S_DONE;
              end
            end
            KIND_COUNT_UP, KIND_TEST_FWD: begin
              start_p = first_x;
            end
            KIND_COUNT_DOWN, KIND_TEST_BWD: begin
              start_p = last_x;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
          p_d = start_p;
        end
      end
      // Split the start position into word index and bit offset.
      S_DIV: begin
        quo_d   = quo_n;
        off_d   = off_n[OW-1:0];
        state_d = (p_q < MAP_P) ? S_FETCH : S_EVAL;
      end
      S_FETCH: begin
        state_d = S_LOAD;
      end
      // Capture the word; never-written words read as zero.
      S_LOAD: begin
        w_d = ((quo_q < PW'(RD)) && valid_q[quo_q[RAW-1:0]]) ? ram_rdata : '0;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        priority if ((kind_q == KIND_FIND_FIRST) && (p_q >= lim_q)) begin
          ans_d   = last_q;
          state_d = S_DONE;
        end else if ((kind_q == KIND_FIND_LAST) && (p_q <= lim_q)) begin
          ans_d   = first_q;
          state_d = S_DONE;
        end else if ((kind_q == KIND_FIND_FIRST) || (kind_q == KIND_FIND_LAST)) begin
          run_d = run_n;
          if (run_n == len_x) begin
            ans_d   = (kind_q == KIND_FIND_FIRST) ? FW'(p_q - len_x + PW'(1)) : FW'(p_q);
            found_d = 1'b1;
            state_d = S_DONE;
          end
        end else if (!bit_v) begin
          if ((kind_q == KIND_COUNT_UP) || (kind_q == KIND_COUNT_DOWN)) begin
            ans_d   = FW'(run_q);
            found_d = (run_q != '0);
          end else begin
            found_d = (run_q >= len_x);
          end
          state_d = S_DONE;
        end else begin
          run_d = run_n;
        end
        // Advance one bit unless finishing.
        if (state_d == S_EVAL) begin
          p_d = p_n;
          if (wrap) begin
            off_d = step_up ? '0 : OFF_TOP;
            quo_d = step_up ? quo_q + PW'(1) : quo_q - PW'(1);
            if (p_n < MAP_P) begin
              state_d = S_FETCH;
            end
          end else begin
            off_d = step_up ? off_q + OW'(1) : off_q - OW'(1);
          end
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      ans_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      ans_q   <= ans_d;
      found_q <= found_d;
    end
  end

  // Walk payload.
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    first_q <= first_d;
    last_q  <= last_d;
    len_q   <= len_d;
    p_q     <= p_d;
    lim_q   <= lim_d;
    run_q   <= run_d;
    quo_q   <= quo_d;
    off_q   <= off_d;
    w_q     <= w_d;
  end

  `BRS_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  `BRS_ASSERT(a_strobe_single, result_valid_o |=> !result_valid_o)
  `BRS_ASSERT(a_strobe_while_busy, result_valid_o |-> busy)
  `BRS_NEVER(a_offset_range, (state_q == S_EVAL) && (32'(off_q) >= WORD_BITS))

endmodule
